>>> design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes of the JSON string unescape block: result kinds,
// error codes and the command word passed from the scanner to the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_NO_QUOTE     = 2'd0;
    localparam logic [1:0] ERR_UNTERMINATED = 2'd1;
    localparam logic [1:0] ERR_BAD_ESCAPE   = 2'd2;
    localparam logic [1:0] ERR_BAD_HEX      = 2'd3;

    typedef struct packed {
        logic        e1_valid;
        logic [20:0] e1_cp;
        logic        e2_valid;
        logic [15:0] e2_cp;
        logic        tail_valid;
        logic [1:0]  tail_kind;
        logic [7:0]  tail_byte;
        logic [1:0]  tail_err;
    } cmd_t;

endpackage

`default_nettype wire

>>> design/jsu_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if / jsu_out_if
// Valid/ready channels for raw JSON bytes and for decoded result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] error_code;
    logic       last;

    modport source (output valid, output kind, output out_byte, output error_code,
                    output last, input ready);
    modport sink (input valid, input kind, input out_byte, input error_code,
                  input last, output ready);
endinterface

`default_nettype wire

>>> design/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Scanner: accepts one JSON byte per transaction, tracks escapes, hex digits
// and surrogate pairs, and queues a command describing the results.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    jsu_in_if.sink             request,
    input  wire logic          q_full,
    output logic               q_push,
    output jsu_pkg::cmd_t      q_data
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_STR,
        M_ESC,
        M_HEX,
        M_HIGH,
        M_HIGH_BS,
        M_LOW_HEX
    } mode_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    mode_t       mode_reg, mode_next;
    logic [1:0]  hc_reg, hc_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] pend_reg, pend_next;

    logic [7:0]  b;
    logic        eoi;
    logic        accept;
    logic        hex_ok;
    logic [3:0]  nibble;
    logic [15:0] acc_shift;
    logic        esc_ok;
    logic [7:0]  esc_char;
    logic        go_idle;
    jsu_pkg::cmd_t cmd;

    assign b      = request.in_byte;
    assign eoi    = request.end_of_input;
    assign request.ready = !q_full;
    assign accept = request.valid && !q_full;

    always_comb
    begin
        hex_ok = 1'b1;
        nibble = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            nibble = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            nibble = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            nibble = 4'(b - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
        end
        if (eoi)
        begin
            hex_ok = 1'b0;
        end
    end

    assign acc_shift = {acc_reg[11:0], nibble};

    always_comb
    begin
        esc_ok   = 1'b1;
        esc_char = 8'h00;
        case (b)
            CH_QUOTE: esc_char = CH_QUOTE;
            CH_BSL:   esc_char = CH_BSL;
            CH_SLASH: esc_char = CH_SLASH;
            CH_B:     esc_char = 8'h08;
            CH_F:     esc_char = 8'h0C;
            CH_N:     esc_char = 8'h0A;
            CH_R:     esc_char = 8'h0D;
            CH_T:     esc_char = 8'h09;
            default:  esc_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg;
        hc_next   = hc_reg;
        acc_next  = acc_reg;
        pend_next = pend_reg;
        go_idle   = 1'b0;
        cmd       = '0;
        case (mode_reg)
            M_STR:
            begin
                if (eoi)
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_kind  = jsu_pkg::KIND_ERROR;
                    cmd.tail_err   = jsu_pkg::ERR_UNTERMINATED;
                    go_idle        = 1'b1;
                end
                else if (b == CH_QUOTE)
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_kind  = jsu_pkg::KIND_END;
                    go_idle        = 1'b1;
                end
                else if (b == CH_BSL)
                begin
                    mode_next = M_ESC;
                end
                else
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_kind  = jsu_pkg::KIND_DATA;
                    cmd.tail_byte  = b;
                end
            end
            M_ESC:
            begin
                if (!eoi && b == CH_U)
                begin
                    mode_next = M_HEX;
                    hc_next   = 2'd0;
                    acc_next  = 16'd0;
                end
                else if (!eoi && esc_ok)
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_kind  = jsu_pkg::KIND_DATA;
                    cmd.tail_byte  = esc_char;
                    mode_next      = M_STR;
                end
                else
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_kind  = jsu_pkg::KIND_ERROR;
                    cmd.tail_err   = jsu_pkg::ERR_BAD_ESCAPE;
                    go_idle        = 1'b1;
                end
            end
            M_HEX:
            begin
                if (!hex_ok)
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_kind  = jsu_pkg::KIND_ERROR;
                    cmd.tail_err   = jsu_pkg::ERR_BAD_HEX;
                    go_idle        = 1'b1;
                end
                else if (hc_reg == 2'd3)
                begin
                    hc_next  = 2'd0;
                    acc_next = 16'd0;
                    if (acc_shift >= HIGH_FIRST && acc_shift <= HIGH_LAST)
                    begin
                        pend_next = acc_shift;
                        mode_next = M_HIGH;
                    end
                    else
                    begin
                        cmd.e1_valid = 1'b1;
                        cmd.e1_cp    = {5'd0, acc_shift};
                        pend_next    = 16'd0;
                        mode_next    = M_STR;
                    end
                end
                else
                begin
                    hc_next  = hc_reg + 2'd1;
                    acc_next = acc_shift;
                end
            end
            M_HIGH:
            begin
                if (!eoi && b == CH_BSL)
                begin
                    mode_next = M_HIGH_BS;
                end
                else
                begin
                    cmd.e1_valid = 1'b1;
                    cmd.e1_cp    = {5'd0, pend_reg};
                    pend_next    = 16'd0;
                    mode_next    = M_STR;
                    if (eoi)
                    begin
                        cmd.tail_valid = 1'b1;
                        cmd.tail_kind  = jsu_pkg::KIND_ERROR;
                        cmd.tail_err   = jsu_pkg::ERR_UNTERMINATED;
                        go_idle        = 1'b1;
                    end
                    else if (b == CH_QUOTE)
                    begin
                        cmd.tail_valid = 1'b1;
                        cmd.tail_kind  = jsu_pkg::KIND_END;
                        go_idle        = 1'b1;
                    end
                    else
                    begin
                        cmd.tail_valid = 1'b1;
                        cmd.tail_kind  = jsu_pkg::KIND_DATA;
                        cmd.tail_byte  = b;
                    end
                end
            end
            M_HIGH_BS:
            begin
                if (!eoi && b == CH_U)
                begin
                    mode_next = M_LOW_HEX;
                    hc_next   = 2'd0;
                    acc_next  = 16'd0;
                end
                else
                begin
                    cmd.e1_valid = 1'b1;
                    cmd.e1_cp    = {5'd0, pend_reg};
                    pend_next    = 16'd0;
                    if (!eoi && esc_ok)
                    begin
                        cmd.tail_valid = 1'b1;
                        cmd.tail_kind  = jsu_pkg::KIND_DATA;
                        cmd.tail_byte  = esc_char;
                        mode_next      = M_STR;
                    end
                    else
                    begin
                        cmd.tail_valid = 1'b1;
                        cmd.tail_kind  = jsu_pkg::KIND_ERROR;
                        cmd.tail_err   = jsu_pkg::ERR_BAD_ESCAPE;
                        go_idle        = 1'b1;
                    end
                end
            end
            M_LOW_HEX:
            begin
                if (!hex_ok)
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_kind  = jsu_pkg::KIND_ERROR;
                    cmd.tail_err   = jsu_pkg::ERR_BAD_HEX;
                    go_idle        = 1'b1;
                end
                else if (hc_reg == 2'd3)
                begin
                    hc_next  = 2'd0;
                    acc_next = 16'd0;
                    if (acc_shift >= LOW_FIRST && acc_shift <= LOW_LAST)
                    begin
                        cmd.e1_valid = 1'b1;
                        cmd.e1_cp    = SUPP_BASE + {1'b0, pend_reg[9:0], acc_shift[9:0]};
                        pend_next    = 16'd0;
                        mode_next    = M_STR;
                    end
                    else
                    begin
                        cmd.e1_valid = 1'b1;
                        cmd.e1_cp    = {5'd0, pend_reg};
                        if (acc_shift >= HIGH_FIRST && acc_shift <= HIGH_LAST)
                        begin
                            pend_next = acc_shift;
                            mode_next = M_HIGH;
                        end
                        else
                        begin
                            cmd.e2_valid = 1'b1;
                            cmd.e2_cp    = acc_shift;
                            pend_next    = 16'd0;
                            mode_next    = M_STR;
                        end
                    end
                end
                else
                begin
                    hc_next  = hc_reg + 2'd1;
                    acc_next = acc_shift;
                end
            end
            default:
            begin
                if (eoi || b != CH_QUOTE)
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_kind  = jsu_pkg::KIND_ERROR;
                    cmd.tail_err   = jsu_pkg::ERR_NO_QUOTE;
                    go_idle        = 1'b1;
                end
                else
                begin
                    mode_next = M_STR;
                end
            end
        endcase
        if (go_idle)
        begin
            mode_next = M_IDLE;
            hc_next   = 2'd0;
            acc_next  = 16'd0;
            pend_next = 16'd0;
        end
    end

    assign q_push = accept && (cmd.e1_valid || cmd.e2_valid || cmd.tail_valid);
    assign q_data = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            hc_reg   <= 2'd0;
            acc_reg  <= 16'd0;
            pend_reg <= 16'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            hc_reg   <= hc_next;
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
        end
    end

endmodule

`default_nettype wire

>>> design/jsu_cmd_queue.sv
// ----------------------------------------------------------------------------
// jsu_cmd_queue
// Short command FIFO between the scanner and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_cmd_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire jsu_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output jsu_pkg::cmd_t      pop_data,
    output logic               empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::cmd_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Emitter: expands each queued command into UTF-8 bytes and any tail item,
// one result per cycle while result.ready allows, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire jsu_pkg::cmd_t q_data,
    input  wire logic          q_empty,
    output logic               q_pop,
    jsu_out_if.source          result
);

    typedef enum logic [1:0] {
        SEL_E1,
        SEL_E2,
        SEL_TAIL
    } sel_t;

    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    function automatic logic [1:0] enc_last_idx(input logic [20:0] cp);
        logic [1:0] n;
        if (cp < 21'h80)
        begin
            n = 2'd0;
        end
        else if (cp < 21'h800)
        begin
            n = 2'd1;
        end
        else if (cp < 21'h10000)
        begin
            n = 2'd2;
        end
        else
        begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] last_idx,
                                            input logic [1:0] idx);
        logic [7:0] v;
        case ({last_idx, idx})
            4'b0000: v = cp[7:0];
            4'b0100: v = LEAD2 | {3'd0, cp[10:6]};
            4'b0101: v = CONT | {2'd0, cp[5:0]};
            4'b1000: v = LEAD3 | {4'd0, cp[15:12]};
            4'b1001: v = CONT | {2'd0, cp[11:6]};
            4'b1010: v = CONT | {2'd0, cp[5:0]};
            4'b1100: v = LEAD4 | {5'd0, cp[20:18]};
            4'b1101: v = CONT | {2'd0, cp[17:12]};
            4'b1110: v = CONT | {2'd0, cp[11:6]};
            4'b1111: v = CONT | {2'd0, cp[5:0]};
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    jsu_pkg::cmd_t cur_reg;
    logic          cur_valid_reg;
    sel_t          sel_reg;
    logic [1:0]    idx_reg;

    logic          out_valid_reg;
    logic [1:0]    kind_reg;
    logic [7:0]    byte_reg;
    logic [1:0]    err_reg;
    logic          last_reg;

    logic [20:0]   cur_cp;
    logic [1:0]    cur_last_idx;
    logic [1:0]    item_kind;
    logic [7:0]    item_byte;
    logic [1:0]    item_err;
    sel_t          sel_next;
    logic [1:0]    idx_next;
    logic          done;
    logic          emit;
    sel_t          load_sel;

    assign cur_cp       = (sel_reg == SEL_E1) ? cur_reg.e1_cp : {5'd0, cur_reg.e2_cp};
    assign cur_last_idx = enc_last_idx(cur_cp);

    always_comb
    begin
        item_kind = jsu_pkg::KIND_DATA;
        item_byte = enc_byte(cur_cp, cur_last_idx, idx_reg);
        item_err  = 2'd0;
        sel_next  = sel_reg;
        idx_next  = idx_reg;
        done      = 1'b0;
        case (sel_reg)
            SEL_E1, SEL_E2:
            begin
                if (idx_reg != cur_last_idx)
                begin
                    idx_next = idx_reg + 2'd1;
                end
                else if (sel_reg == SEL_E1 && cur_reg.e2_valid)
                begin
                    sel_next = SEL_E2;
                    idx_next = 2'd0;
                end
                else if (cur_reg.tail_valid)
                begin
                    sel_next = SEL_TAIL;
                    idx_next = 2'd0;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            default:
            begin
                item_kind = cur_reg.tail_kind;
                item_byte = cur_reg.tail_byte;
                item_err  = cur_reg.tail_err;
                done      = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (q_data.e1_valid)
        begin
            load_sel = SEL_E1;
        end
        else if (q_data.e2_valid)
        begin
            load_sel = SEL_E2;
        end
        else
        begin
            load_sel = SEL_TAIL;
        end
    end

    assign emit  = cur_valid_reg && (!out_valid_reg || result.ready);
    assign q_pop = (!cur_valid_reg || (emit && done)) && !q_empty;

    assign result.valid      = out_valid_reg;
    assign result.kind       = kind_reg;
    assign result.out_byte   = byte_reg;
    assign result.error_code = err_reg;
    assign result.last       = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            sel_reg       <= SEL_E1;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            kind_reg      <= 2'd0;
            byte_reg      <= 8'd0;
            err_reg       <= 2'd0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                kind_reg      <= item_kind;
                byte_reg      <= item_byte;
                err_reg       <= item_err;
                last_reg      <= done;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (q_pop)
            begin
                cur_reg       <= q_data;
                cur_valid_reg <= 1'b1;
                sel_reg       <= load_sel;
                idx_reg       <= 2'd0;
            end
            else if (emit && done)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                sel_reg <= sel_next;
                idx_reg <= idx_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/json_string_unescape_utf8.sv
// Path: a byte's first result goes through the command queue, the emitter's
//   command register and output register; a byte with no result leaves nothing.
// Throughput: one input byte per cycle while the queue has room, one result
//   per cycle via the single output register while ready; queue absorbs bursts.
// Reset: scanner returns to idle (awaiting the opening quote), queue empties.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming decoder of one quoted JSON string into UTF-8 bytes: scanner,
// command queue and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    jsu_in_if.sink    request,
    jsu_out_if.source result
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    jsu_pkg::cmd_t q_push_data;
    jsu_pkg::cmd_t q_pop_data;

    jsu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_push_data)
    );

    jsu_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    jsu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_pop_data),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire
